// ===== hw/rtl/tgad_pkg.sv =====
// ----------------------------------------------------------------------------
// tgad_pkg
// Shared types and codes for the TGA image stream decoder.
// ----------------------------------------------------------------------------
package tgad_pkg;

  // default largest image side in pixels
  localparam int unsigned MAX_DIM_DEFAULT = 4096;

  // header layout
  localparam int unsigned HDR_BYTES   = 18;
  localparam logic [4:0]  HB_ID_LEN   = 5'd0;
  localparam logic [4:0]  HB_CMAP     = 5'd1;
  localparam logic [4:0]  HB_TYPE     = 5'd2;
  localparam logic [4:0]  HB_WIDTH_L  = 5'd12;
  localparam logic [4:0]  HB_WIDTH_H  = 5'd13;
  localparam logic [4:0]  HB_HEIGHT_L = 5'd14;
  localparam logic [4:0]  HB_HEIGHT_H = 5'd15;
  localparam logic [4:0]  HB_DEPTH    = 5'd16;
  localparam logic [4:0]  HB_LAST     = 5'(HDR_BYTES - 1);

  // image types and pixel depths
  localparam logic [7:0] TYPE_TRUE = 8'd2;
  localparam logic [7:0] TYPE_GREY = 8'd3;
  localparam logic [7:0] TYPE_RLE  = 8'd10;
  localparam logic [7:0] DEPTH_8   = 8'd8;
  localparam logic [7:0] DEPTH_24  = 8'd24;
  localparam logic [7:0] DEPTH_32  = 8'd32;

  // rle packet head
  localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;
  localparam logic [7:0] ALPHA_OPAQUE   = 8'd255;
  localparam logic [15:0] DIM_SIGN      = 16'h8000;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_IDSKIP = 3'd1,
    PH_PLAIN  = 3'd2,
    PH_PKHEAD = 3'd3,
    PH_PKDATA = 3'd4,
    PH_DONE   = 3'd5,
    PH_ERROR  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TYPE     = 3'd1,
    ERR_CMAP     = 3'd2,
    ERR_DEPTH    = 3'd3,
    ERR_GREY     = 3'd4,
    ERR_SIZE     = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_t;

endpackage

// ===== hw/rtl/tga_image_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// tga_image_stream_decoder
// Byte-serial TGA parser: header check, ID skip, grey/BGR(A)/RLE decode into
// RGBA pixel runs in file order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+---------------------------------
//  in_     | input     | in_valid/in_stall  | data_byte, last_byte
//  out_    | output    | out_valid/out_stall| kind, error_code, pixel_index,
//          |           |                    | run_length, rgba, image_done,
//          |           |                    | frame_width, frame_height
//
//  one byte per cycle while the output is not stalled; each byte is decoded in the cycle it transfers and its
//  result (zero or one) lands in the output register on the same edge
//  the result path runs through the run-length clip and pixel
//  count add between the state registers and the output register
//  a byte is taken whenever the output register is empty or being drained
//  synchronous active-low reset; no clearing pass, decoder is ready at once
//  the last byte of a file returns all decode state to the header phase
//
module tga_image_stream_decoder #(
  parameter int unsigned MAX_DIM = tgad_pkg::MAX_DIM_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // result stream out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [23:0] out_pixel_index,
  output logic [7:0]  out_run_length,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic        out_image_done,
  output logic [12:0] out_frame_width,
  output logic [12:0] out_frame_height
);
  import tgad_pkg::*;

  // pixel count width, enough for MAX_DIM squared
  localparam int unsigned PIX_W = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int unsigned CMP_W = (PIX_W > 8) ? PIX_W : 8;

  // decode state
  phase_t            phase_r, phase_nxt;
  logic [4:0]        hcount_r, hcount_nxt;
  logic [7:0]        id_skip_r, id_skip_nxt;
  logic [7:0]        id_len_r, id_len_nxt;
  logic [7:0]        cmap_r, cmap_nxt;
  logic [7:0]        type_r, type_nxt;
  logic [7:0]        depth_r, depth_nxt;
  logic [15:0]       width_r, width_nxt;
  logic [15:0]       height_r, height_nxt;
  logic [PIX_W-1:0]  total_r, total_nxt;
  logic [PIX_W-1:0]  pix_done_r, pix_done_nxt;
  logic [7:0]        pkt_left_r, pkt_left_nxt;
  logic              pkt_run_r, pkt_run_nxt;
  logic [1:0]        byte_pos_r, byte_pos_nxt;
  logic [7:0]        pix_bytes_r [4];
  logic [7:0]        pix_bytes_nxt [4];

  // output register
  logic              out_valid_r;
  logic [1:0]        kind_r, kind_nxt;
  logic [2:0]        err_r, err_nxt;
  logic [23:0]       index_r, index_nxt;
  logic [7:0]        run_r, run_nxt;
  logic [7:0]        red_r, red_nxt;
  logic [7:0]        green_r, green_nxt;
  logic [7:0]        blue_r, blue_nxt;
  logic [7:0]        alpha_r, alpha_nxt;
  logic              done_r, done_nxt;
  logic [12:0]       img_w_r, img_w_nxt;
  logic [12:0]       img_h_r, img_h_nxt;
  logic              emit;

  // helpers
  logic              in_xfer;
  logic [31:0]       area;
  logic [2:0]        bpp;
  logic [2:0]        pos_inc;
  err_t              hdr_err;
  logic [PIX_W-1:0]  pix_left;
  logic [7:0]        run_want;
  logic [7:0]        run_len;
  logic [PIX_W-1:0]  pix_after;
  logic [PIX_W+23:0] index_wide;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign area    = width_r * height_r;
  assign bpp     = (type_r == TYPE_GREY) ? 3'd1 : depth_r[5:3];
  assign pos_inc = {1'b0, byte_pos_r} + 3'd1;

  // header check, first failing test wins
  always_comb begin
    priority if (type_r != TYPE_TRUE && type_r != TYPE_RLE && type_r != TYPE_GREY) begin
      hdr_err = ERR_TYPE;
    end else if (cmap_r != 8'd0) begin
      hdr_err = ERR_CMAP;
    end else if (type_r != TYPE_GREY && depth_r != DEPTH_32 && depth_r != DEPTH_24) begin
      hdr_err = ERR_DEPTH;
    end else if (type_r == TYPE_GREY && depth_r != DEPTH_8) begin
      hdr_err = ERR_GREY;
    end else if (width_r == 16'd0 || width_r >= DIM_SIGN || 17'(width_r) > 17'(MAX_DIM) ||
                 height_r == 16'd0 || height_r >= DIM_SIGN ||
                 17'(height_r) > 17'(MAX_DIM)) begin
      hdr_err = ERR_SIZE;
    end else begin
      hdr_err = ERR_NONE;
    end
  end

  // run clipped to the pixels still missing from the image
  assign pix_left   = total_r - pix_done_r;
  assign run_want   = (phase_r == PH_PKDATA && pkt_run_r) ? pkt_left_r : 8'd1;
  assign run_len    = (CMP_W'(pix_left) < CMP_W'(run_want)) ? 8'(pix_left) : run_want;
  assign pix_after  = pix_done_r + PIX_W'(run_len);
  assign index_wide = {24'd0, pix_done_r};

  always_comb begin
    phase_nxt    = phase_r;
    hcount_nxt   = hcount_r;
    id_skip_nxt  = id_skip_r;
    id_len_nxt   = id_len_r;
    cmap_nxt     = cmap_r;
    type_nxt     = type_r;
    depth_nxt    = depth_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    total_nxt    = total_r;
    pix_done_nxt = pix_done_r;
    pkt_left_nxt = pkt_left_r;
    pkt_run_nxt  = pkt_run_r;
    byte_pos_nxt = byte_pos_r;
    for (int i = 0; i < 4; i++) begin
      pix_bytes_nxt[i] = pix_bytes_r[i];
    end
    emit      = 1'b0;
    kind_nxt  = KIND_RUN;
    err_nxt   = ERR_NONE;
    index_nxt = 24'd0;
    run_nxt   = 8'd0;
    red_nxt   = 8'd0;
    green_nxt = 8'd0;
    blue_nxt  = 8'd0;
    alpha_nxt = 8'd0;
    done_nxt  = 1'b0;
    img_w_nxt = 13'd0;
    img_h_nxt = 13'd0;

    unique case (phase_r)
      PH_HEADER: begin
        unique case (hcount_r)
          HB_ID_LEN:   id_len_nxt = in_data_byte;
          HB_CMAP:     cmap_nxt = in_data_byte;
          HB_TYPE:     type_nxt = in_data_byte;
          HB_WIDTH_L:  width_nxt = {width_r[15:8], in_data_byte};
          HB_WIDTH_H:  width_nxt = {in_data_byte, width_r[7:0]};
          HB_HEIGHT_L: height_nxt = {height_r[15:8], in_data_byte};
          HB_HEIGHT_H: height_nxt = {in_data_byte, height_r[7:0]};
          HB_DEPTH:    depth_nxt = in_data_byte;
          default:     ;
        endcase
        hcount_nxt = hcount_r + 5'd1;
        if (hcount_r == HB_LAST) begin
          emit = 1'b1;
          if (hdr_err != ERR_NONE) begin
            phase_nxt = PH_ERROR;
            kind_nxt  = KIND_ERROR;
            err_nxt   = hdr_err;
          end else begin
            kind_nxt     = KIND_HEADER;
            img_w_nxt    = width_r[12:0];
            img_h_nxt    = height_r[12:0];
            total_nxt    = PIX_W'(area);
            id_skip_nxt  = id_len_r;
            byte_pos_nxt = 2'd0;
            if (id_len_r != 8'd0) begin
              phase_nxt = PH_IDSKIP;
            end else begin
              phase_nxt = (type_r == TYPE_RLE) ? PH_PKHEAD : PH_PLAIN;
            end
          end
        end
      end
      PH_IDSKIP: begin
        id_skip_nxt = id_skip_r - 8'd1;
        if (id_skip_r == 8'd1) begin
          byte_pos_nxt = 2'd0;
          phase_nxt    = (type_r == TYPE_RLE) ? PH_PKHEAD : PH_PLAIN;
        end
      end
      PH_PKHEAD: begin
        pkt_run_nxt  = in_data_byte[7];
        pkt_left_nxt = (in_data_byte & PKT_COUNT_MASK) + 8'd1;
        byte_pos_nxt = 2'd0;
        phase_nxt    = PH_PKDATA;
      end
      PH_PLAIN, PH_PKDATA: begin
        pix_bytes_nxt[byte_pos_r] = in_data_byte;
        byte_pos_nxt = pos_inc[1:0];
        if (pos_inc >= bpp) begin
          // pixel complete
          byte_pos_nxt = 2'd0;
          emit         = 1'b1;
          kind_nxt     = KIND_RUN;
          index_nxt    = index_wide[23:0];
          run_nxt      = run_len;
          pix_done_nxt = pix_after;
          if (bpp == 3'd1) begin
            red_nxt   = pix_bytes_nxt[0];
            green_nxt = pix_bytes_nxt[0];
            blue_nxt  = pix_bytes_nxt[0];
            alpha_nxt = ALPHA_OPAQUE;
          end else begin
            red_nxt   = pix_bytes_nxt[2];
            green_nxt = pix_bytes_nxt[1];
            blue_nxt  = pix_bytes_nxt[0];
            alpha_nxt = (bpp == 3'd4) ? pix_bytes_nxt[3] : ALPHA_OPAQUE;
          end
          if (pix_after >= total_r) begin
            phase_nxt = PH_DONE;
            done_nxt  = 1'b1;
          end else if (phase_r == PH_PKDATA) begin
            if (pkt_run_r) begin
              phase_nxt = PH_PKHEAD;
            end else begin
              pkt_left_nxt = pkt_left_r - 8'd1;
              if (pkt_left_r == 8'd1) phase_nxt = PH_PKHEAD;
            end
          end
        end
      end
      default: ;
    endcase

    // end of file: truncation check, then back to the header phase
    if (in_last_byte) begin
      if (phase_nxt != PH_DONE && phase_nxt != PH_ERROR) begin
        emit      = 1'b1;
        kind_nxt  = KIND_ERROR;
        err_nxt   = ERR_TRUNC;
        index_nxt = 24'd0;
        run_nxt   = 8'd0;
        red_nxt   = 8'd0;
        green_nxt = 8'd0;
        blue_nxt  = 8'd0;
        alpha_nxt = 8'd0;
        done_nxt  = 1'b0;
        img_w_nxt = 13'd0;
        img_h_nxt = 13'd0;
      end
      phase_nxt    = PH_HEADER;
      hcount_nxt   = 5'd0;
      id_skip_nxt  = 8'd0;
      id_len_nxt   = 8'd0;
      cmap_nxt     = 8'd0;
      type_nxt     = 8'd0;
      depth_nxt    = 8'd0;
      width_nxt    = 16'd0;
      height_nxt   = 16'd0;
      pix_done_nxt = '0;
      total_nxt    = '0;
      pkt_left_nxt = 8'd0;
      pkt_run_nxt  = 1'b0;
      byte_pos_nxt = 2'd0;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      hcount_r    <= 5'd0;
      id_skip_r   <= 8'd0;
      id_len_r    <= 8'd0;
      cmap_r      <= 8'd0;
      type_r      <= 8'd0;
      depth_r     <= 8'd0;
      width_r     <= 16'd0;
      height_r    <= 16'd0;
      total_r     <= '0;
      pix_done_r  <= '0;
      pkt_left_r  <= 8'd0;
      pkt_run_r   <= 1'b0;
      byte_pos_r  <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase_r    <= phase_nxt;
        hcount_r   <= hcount_nxt;
        id_skip_r  <= id_skip_nxt;
        id_len_r   <= id_len_nxt;
        cmap_r     <= cmap_nxt;
        type_r     <= type_nxt;
        depth_r    <= depth_nxt;
        width_r    <= width_nxt;
        height_r   <= height_nxt;
        total_r    <= total_nxt;
        pix_done_r <= pix_done_nxt;
        pkt_left_r <= pkt_left_nxt;
        pkt_run_r  <= pkt_run_nxt;
        byte_pos_r <= byte_pos_nxt;
      end
      if (in_xfer && emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pixel assembly bytes and result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int i = 0; i < 4; i++) begin
        pix_bytes_r[i] <= pix_bytes_nxt[i];
      end
    end
    if (in_xfer && emit) begin
      kind_r  <= kind_nxt;
      err_r   <= err_nxt;
      index_r <= index_nxt;
      run_r   <= run_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
      alpha_r <= alpha_nxt;
      done_r  <= done_nxt;
      img_w_r <= img_w_nxt;
      img_h_r <= img_h_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_error_code   = err_r;
  assign out_pixel_index  = index_r;
  assign out_run_length   = run_r;
  assign out_red          = red_r;
  assign out_green        = green_r;
  assign out_blue         = blue_r;
  assign out_alpha        = alpha_r;
  assign out_image_done   = done_r;
  assign out_frame_width  = img_w_r;
  assign out_frame_height = img_h_r;

`ifndef NO_ASSERTIONS
  // finished image means every pixel was counted
  a_done_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DONE |-> pix_done_r == total_r)
    else $error("done phase with pixel count short of image area");

  // pixel count never passes the image area
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pix_done_r <= total_r)
    else $error("pixel count beyond image area");

  // last byte returns the parser to the header phase
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_last_byte |=> phase_r == PH_HEADER && hcount_r == 5'd0)
    else $error("decoder not reset after last byte");

  // a pixel run result always carries at least one pixel
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && kind_r == KIND_RUN |-> run_r != 8'd0)
    else $error("empty pixel run");
`endif

endmodule
